// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the gradient position block, included by its top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gradient position check failed");
// Clocked check that also runs during reset.
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("gradient position reset check failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== rtl/gpp_pkg.sv =====
// Shared widths, constants, types and helpers of the gradient position pipeline.
package gpp_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int POS_BITS        = 16;
  localparam int ANGLE_STAGES    = 16;

  localparam int CFG_W  = 20;
  localparam int PIX_W  = 16;
  localparam int CFG_AW = 5;

  // register indexes; the byte address is four times the index
  typedef enum logic [CFG_AW-3:0] {
    REG_START_X, REG_START_Y, REG_END_X, REG_END_Y,
    REG_SHAPE, REG_SPREAD, REG_REVERSE
  } reg_t;

  // shape codes; the two unused codes give a zero position
  typedef enum logic [2:0] {
    SHAPE_LINEAR, SHAPE_BILINEAR, SHAPE_RADIAL, SHAPE_SQUARE,
    SHAPE_CONICAL, SHAPE_CONICAL_SYM, SHAPE_UNUSED6, SHAPE_UNUSED7
  } shape_t;

  // spread codes; the unused code falls to clamp
  typedef enum logic [1:0] {
    SPREAD_CLAMP, SPREAD_REPEAT, SPREAD_MIRROR, SPREAD_UNUSED3
  } spread_t;

  // offset from the start point and vector length, signed
  localparam int PW = ((PIX_W + COORD_FRAC_BITS) > CFG_W ?
                       (PIX_W + COORD_FRAC_BITS) : CFG_W) + 1;
  localparam int NW = 2 * PW;
  localparam int QW = NW + 2 * POS_BITS;
  localparam int SQ = QW / 2;

  localparam int CORDIC_SHIFT = 30;
  localparam int CXW          = PW + CORDIC_SHIFT + 2;
  localparam int TABLE_LEN    = 24;
  localparam int SHW          = $clog2(TABLE_LEN);

  // depth of the delay line that lines the conical result up with the root
  localparam int CON_DLY = QW + SQ + 1 - ANGLE_STAGES;

  typedef logic [31:0] turn_t;

  localparam turn_t HALF_TURN = 32'h8000_0000;

  localparam turn_t ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] rem;
    logic [QW-1:0] dq;
    logic [NW-1:0] den;
  } div_t;

  typedef struct packed {
    logic          valid;
    logic [QW-1:0] x;
    logic [SQ-1:0] root;
    logic [SQ+1:0] rem;
  } sqrt_t;

  typedef struct packed {
    logic signed [CXW-1:0] x;
    logic signed [CXW-1:0] y;
    turn_t                 z;
  } rot_t;

  // position reduced to what the spread stage looks at
  typedef struct packed {
    logic                ge_one;
    logic                nz;
    logic [POS_BITS:0]   low;
  } pos_t;

  function automatic pos_t to_pos(input logic [QW-1:0] v);
    pos_t p;
    p.ge_one = |(v >> POS_BITS);
    p.nz     = |v;
    p.low    = v[POS_BITS:0];
    return p;
  endfunction

endpackage

// ===== rtl/gradient_position_per_pixel.sv =====
// Gradient position per pixel: config registers, front end, cell chains, spread.
// Pipeline: 4 front stages, 74 divider cells, 37 square root cells and 1 spread/output
//   register between input accept and out_valid.
// Throughput: one beat per cycle while the output is not stalled; depth is set by the divider and root chains.
// A stalled output freezes the whole pipeline; in_stall rises only then.
// Reset (synchronous, rst_n low) clears all valid bits and config registers.
`include "assert_macros.svh"

module gradient_position_per_pixel import gpp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_pixel_x,
  input  logic signed [15:0]  in_pixel_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_position
);

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0]  cfg_start_x_r, cfg_start_y_r, cfg_end_x_r, cfg_end_y_r;
  logic [2:0]        cfg_shape_r;
  logic [1:0]        cfg_spread_r;
  logic              cfg_reverse_r;
  logic              cfg_we;
  logic [CFG_AW-3:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_x_r <= '0;
      cfg_start_y_r <= '0;
      cfg_end_x_r   <= '0;
      cfg_end_y_r   <= '0;
      cfg_shape_r   <= '0;
      cfg_spread_r  <= '0;
      cfg_reverse_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_X: cfg_start_x_r <= pwdata[CFG_W-1:0];
        REG_START_Y: cfg_start_y_r <= pwdata[CFG_W-1:0];
        REG_END_X:   cfg_end_x_r   <= pwdata[CFG_W-1:0];
        REG_END_Y:   cfg_end_y_r   <= pwdata[CFG_W-1:0];
        REG_SHAPE:   cfg_shape_r   <= pwdata[2:0];
        REG_SPREAD:  cfg_spread_r  <= pwdata[1:0];
        REG_REVERSE: cfg_reverse_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_X: prdata = 32'(cfg_start_x_r);
      REG_START_Y: prdata = 32'(cfg_start_y_r);
      REG_END_X:   prdata = 32'(cfg_end_x_r);
      REG_END_Y:   prdata = 32'(cfg_end_y_r);
      REG_SHAPE:   prdata = 32'(cfg_shape_r);
      REG_SPREAD:  prdata = 32'(cfg_spread_r);
      REG_REVERSE: prdata = 32'(cfg_reverse_r);
      default:     prdata = '0;
    endcase
  end

  // ------------------------------------------------------ pipeline control
  // Every stage advances together; only a waiting output beat holds them.
  logic en;
  logic out_valid_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;

  // vector d = end - start; the user must keep config static while beats are in flight (not enforced)
  logic signed [PW-1:0] dx, dy;
  assign dx = PW'($signed(cfg_end_x_r)) - PW'($signed(cfg_start_x_r));
  assign dy = PW'($signed(cfg_end_y_r)) - PW'($signed(cfg_start_y_r));

  // ---------------------------------------------- stage 1: pixel offset p
  logic signed [PW-1:0] px_r, py_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= (PW'(in_pixel_x) <<< COORD_FRAC_BITS) - PW'($signed(cfg_start_x_r));
      py_r <= (PW'(in_pixel_y) <<< COORD_FRAC_BITS) - PW'($signed(cfg_start_y_r));
    end
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  // ---------------------------------------------------- stage 2: products
  logic signed [NW-1:0] pxdx_r, pydy_r, pydx_r, pxdy_r;
  logic [NW-1:0]        pxpx_r, pypy_r, dxdx_r, dydy_r;
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxdx_r <= px_r * dx;
      pydy_r <= py_r * dy;
      pydx_r <= py_r * dx;
      pxdy_r <= px_r * dy;
      pxpx_r <= px_r * px_r;
      pypy_r <= py_r * py_r;
      dxdx_r <= dx * dx;
      dydy_r <= dy * dy;
    end
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  // -------------------------------------------------------- stage 3: sums
  logic signed [NW:0] dot_r, cross_r;
  logic [NW-1:0]      a_r, len2_r;
  logic               v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r   <= (NW+1)'(pxdx_r) + (NW+1)'(pydy_r);
      cross_r <= (NW+1)'(pydx_r) - (NW+1)'(pxdy_r);
      a_r     <= pxpx_r + pypy_r;
      len2_r  <= dxdx_r + dydy_r;
    end
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  // ----------------------------------------- stage 4: dividend and divisor
  logic [NW-1:0] dot_mag, cross_mag, num;
  logic          len_zero;
  div_t          s4_nxt, s4_r;
  logic          s4_neg_nxt, s4_neg_r;

  always_comb begin
    dot_mag   = NW'(dot_r[NW] ? -dot_r : dot_r);
    cross_mag = NW'(cross_r[NW] ? -cross_r : cross_r);
    len_zero  = (len2_r == '0);
    num       = ((cfg_shape_r == SHAPE_SQUARE) && (cross_mag > dot_mag)) ?
                cross_mag : dot_mag;
    s4_nxt.valid = v3_r;
    s4_nxt.rem   = '0;
    s4_nxt.den   = len_zero ? NW'(1) : len2_r;
    case (cfg_shape_r)
      SHAPE_LINEAR, SHAPE_BILINEAR, SHAPE_SQUARE:
        s4_nxt.dq = QW'(num) << POS_BITS;
      SHAPE_RADIAL:
        s4_nxt.dq = QW'(a_r) << (2 * POS_BITS);
      default:
        s4_nxt.dq = '0;
    endcase
    // zero-length vector: divide zero by one
    if (len_zero) begin
      s4_nxt.dq = '0;
    end
    s4_neg_nxt = (cfg_shape_r == SHAPE_LINEAR) && dot_r[NW] && !len_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r     <= s4_nxt;
      s4_neg_r <= s4_neg_nxt;
    end
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end
  end

  // ------------------------------------------------------- divider chain
  // Quotient of the dividend by |d|^2, one bit per cell, MSB first.
  div_t div_c [QW+1];

  assign div_c[0] = s4_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    gpp_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_d  (div_c[k]),
      .out_d (div_c[k+1])
    );
  end

  // ---------------------------------------------------- square root chain
  // Root of the quotient for the radial shape, two quotient bits per cell.
  sqrt_t sq_c [SQ+1];

  always_comb begin
    sq_c[0].valid = div_c[QW].valid;
    sq_c[0].x     = div_c[QW].dq;
    sq_c[0].root  = '0;
    sq_c[0].rem   = '0;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    gpp_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_s  (sq_c[k]),
      .out_s (sq_c[k+1])
    );
  end

  // -------------------------------------------------------- CORDIC chains
  // Two angle chains, one for p and one for d, start from stage 1.
  function automatic rot_t rot_init(input logic signed [PW-1:0] x,
                                    input logic signed [PW-1:0] y);
    rot_t                  r;
    logic signed [CXW-1:0] xe, ye;
    xe = CXW'(x);
    ye = CXW'(y);
    r.z = '0;
    // fold the left half plane over by half a turn
    if (x[PW-1]) begin
      xe  = -xe;
      ye  = -ye;
      r.z = HALF_TURN;
    end
    r.x = xe <<< CORDIC_SHIFT;
    r.y = ye <<< CORDIC_SHIFT;
    return r;
  endfunction

  rot_t rot_p [ANGLE_STAGES+1];
  rot_t rot_d [ANGLE_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rot_p[0] <= rot_init(px_r, py_r);
      rot_d[0] <= rot_init(dx, dy);
    end
  end

  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cordic
    gpp_cordic_cell u_p (
      .clk     (clk),
      .en      (en),
      .shift   (SHW'(i)),
      .in_rot  (rot_p[i]),
      .out_rot (rot_p[i+1])
    );
    gpp_cordic_cell u_d (
      .clk     (clk),
      .en      (en),
      .shift   (SHW'(i)),
      .in_rot  (rot_d[i]),
      .out_rot (rot_d[i+1])
    );
  end

  // angle difference into a position; symmetric mode doubles and folds
  turn_t       diff;
  logic [32:0] con_m;
  pos_t        con_r;

  always_comb begin
    diff = rot_p[ANGLE_STAGES].z - rot_d[ANGLE_STAGES].z;
    if (cfg_shape_r == SHAPE_CONICAL_SYM) begin
      if (!diff[31]) begin
        con_m = {1'b0, diff} >> (31 - POS_BITS);
      end else begin
        con_m = (33'h1_0000_0000 - {1'b0, diff}) >> (31 - POS_BITS);
      end
    end else begin
      con_m = {1'b0, diff} >> (32 - POS_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      con_r <= to_pos(QW'(con_m));
    end
  end

  // ------------------------------------------------------ side band lines
  // Hold the sign, the linear result and the conical result until the
  // beat leaves the root chain.
  logic neg_dly [QW+SQ];
  pos_t lin_dly [SQ];
  pos_t con_dly [CON_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      neg_dly[0] <= s4_neg_r;
      lin_dly[0] <= to_pos(div_c[QW].dq);
      con_dly[0] <= con_r;
      for (int k = 1; k < QW + SQ; k++) begin
        neg_dly[k] <= neg_dly[k-1];
      end
      for (int k = 1; k < SQ; k++) begin
        lin_dly[k] <= lin_dly[k-1];
      end
      for (int k = 1; k < CON_DLY; k++) begin
        con_dly[k] <= con_dly[k-1];
      end
    end
  end

  // ------------------------------------------------- spread and reverse
  pos_t                pos;
  logic                neg;
  logic [POS_BITS-1:0] fr, fr_inv, v;
  logic [15:0]         out_position_r, out_position_nxt;

  always_comb begin
    case (cfg_shape_r)
      SHAPE_LINEAR, SHAPE_BILINEAR, SHAPE_SQUARE: pos = lin_dly[SQ-1];
      SHAPE_RADIAL:                     pos = to_pos(QW'(sq_c[SQ].root));
      SHAPE_CONICAL, SHAPE_CONICAL_SYM: pos = con_dly[CON_DLY-1];
      default:                          pos = '0;
    endcase
    neg    = neg_dly[QW+SQ-1];
    fr     = pos.low[POS_BITS-1:0];
    fr_inv = ~fr + 1'b1;
    case (cfg_spread_r)
      SPREAD_REPEAT: begin
        if (!neg && pos.nz) begin
          v = fr;
        end else begin
          v = (fr == '0) ? '1 : fr_inv;
        end
      end
      SPREAD_MIRROR: begin
        if (pos.low[POS_BITS]) begin
          v = (fr == '0) ? '1 : fr_inv;
        end else begin
          v = fr;
        end
      end
      default: begin
        if (neg || !pos.nz) begin
          v = '0;
        end else begin
          v = pos.ge_one ? '1 : fr;
        end
      end
    endcase
    if (cfg_reverse_r) begin
      v = ~v;
    end
    out_position_nxt = 16'(v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_position_r <= out_position_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_c[SQ].valid;
    end
  end

  assign out_position = out_position_r;

  // ----------------------------------------------------------- checks
  `ASSERT_NORST(a_rst_clears_out, clk, !rst_n |=> !out_valid_r)
  `ASSERT_CLK(a_root_to_out, clk, rst_n, en && sq_c[SQ].valid |=> out_valid_r)
  `ASSERT_CLK(a_hold_frozen, clk, rst_n, !en |=> $stable(out_position_r) && $stable(div_c[QW].valid))
  `ASSERT_CLK(a_div_rem, clk, rst_n, div_c[QW].valid |-> div_c[QW].rem < div_c[QW].den)

endmodule

// ===== rtl/gpp_div_cell.sv =====
// One restoring division step: shift in a dividend bit, subtract when it fits.
module gpp_div_cell import gpp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t in_d,
  output div_t out_d
);

  div_t        out_r, out_nxt;
  logic [NW:0] trial;
  logic        ge;

  always_comb begin
    trial         = {in_d.rem, in_d.dq[QW-1]};
    ge            = trial >= {1'b0, in_d.den};
    out_nxt.valid = in_d.valid;
    out_nxt.den   = in_d.den;
    out_nxt.dq    = {in_d.dq[QW-2:0], ge};
    out_nxt.rem   = ge ? NW'(trial - {1'b0, in_d.den}) : trial[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_d = out_r;

endmodule

// ===== rtl/gpp_sqrt_cell.sv =====
// One digit of the bitwise integer square root: take two bits, try root*4+1.
module gpp_sqrt_cell import gpp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  sqrt_t in_s,
  output sqrt_t out_s
);

  sqrt_t         out_r, out_nxt;
  logic [SQ+3:0] acc;
  logic [SQ+3:0] trial;
  logic          ge;

  always_comb begin
    acc           = {in_s.rem, in_s.x[QW-1:QW-2]};
    trial         = {2'b00, in_s.root, 2'b01};
    ge            = acc >= trial;
    out_nxt.valid = in_s.valid;
    out_nxt.x     = {in_s.x[QW-3:0], 2'b00};
    out_nxt.root  = {in_s.root[SQ-2:0], ge};
    out_nxt.rem   = ge ? (SQ+2)'(acc - trial) : acc[SQ+1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_s = out_r;

endmodule

// ===== rtl/gpp_cordic_cell.sv =====
// One vectoring CORDIC rotation: drive y toward zero and accumulate the angle.
module gpp_cordic_cell import gpp_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [SHW-1:0] shift,
  input  rot_t           in_rot,
  output rot_t           out_rot
);

  rot_t                  out_r, out_nxt;
  logic signed [CXW-1:0] xs, ys;

  always_comb begin
    xs      = in_rot.x >>> shift;
    ys      = in_rot.y >>> shift;
    out_nxt = in_rot;
    if (!in_rot.y[CXW-1] && (in_rot.y != '0)) begin
      out_nxt.x = in_rot.x + ys;
      out_nxt.y = in_rot.y - xs;
      out_nxt.z = in_rot.z + ATAN_TURNS[shift];
    end else if (in_rot.y[CXW-1]) begin
      out_nxt.x = in_rot.x - ys;
      out_nxt.y = in_rot.y + xs;
      out_nxt.z = in_rot.z - ATAN_TURNS[shift];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_rot = out_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the gradient position pipeline: directed and random pixels.
module testbench;
  import gpp_pkg::*;

  typedef struct {
    logic signed [19:0] start_x, start_y, end_x, end_y;
    shape_t             shape;
    spread_t            spread;
    logic               reverse;
  } gradient_cfg_t;

  typedef struct {
    logic signed [15:0] x, y;
  } pixel_t;

  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 130;
  localparam int RANDOM_PIXELS = 850;
  localparam longint unsigned POS_ONE = 64'd1 << POS_BITS;
  localparam longint unsigned POS_MAX = POS_ONE - 1;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [15:0]  in_pixel_x = '0, in_pixel_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [15:0]         out_position;

  gradient_cfg_t       cfg;            // shadow of the block's registers
  pixel_t              pending_pixels[$];
  logic [15:0]         expected_positions[$];
  int                  pixels_queued = 0;
  int                  positions_checked = 0;
  int                  mismatches = 0;
  int                  send_idle_pct = 27, recv_idle_pct = 47;
  int                  stuck_cycles = 0;

  gradient_position_per_pixel u_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_pixel_x, .in_pixel_y,
    .out_valid, .out_stall, .out_position
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // floor(num * 2^POS_BITS / den), den nonzero
  function automatic longint unsigned scaled_quotient(longint unsigned num,
                                                      longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < POS_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // one digit of the restoring square root
  function automatic void root_digit(inout longint unsigned root, rem,
                                     input logic [1:0] pair);
    longint unsigned trial;
    trial = (root << 2) | 1;
    rem = (rem << 2) | pair;
    if (rem >= trial) begin
      rem = rem - trial;
      root = (root << 1) | 1;
    end else begin
      root = root << 1;
    end
  endfunction

  // CORDIC atan2 in 32 bit turns; a zero vector has angle zero
  function automatic logic [31:0] angle_turns(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (x == 0 && y == 0) return z;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    x = x <<< CORDIC_SHIFT;
    y = y <<< CORDIC_SHIFT;
    for (int i = 0; i < ANGLE_STAGES && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += ATAN_TURNS[i];
      end else if (y < 0) begin
        x -= ys;
        y += xs;
        z -= ATAN_TURNS[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] gradient_position(pixel_t pix);
    longint sx, sy, dx, dy, px, py, dot, crs;
    longint unsigned len2, m, fr, v, a, b, q, r, root, rem;
    logic [1:0] pair;
    logic [31:0] diff;
    bit neg;
    sx = longint'(cfg.start_x);
    sy = longint'(cfg.start_y);
    dx = longint'(cfg.end_x) - sx;
    dy = longint'(cfg.end_y) - sy;
    px = (longint'(pix.x) <<< COORD_FRAC_BITS) - sx;
    py = (longint'(pix.y) <<< COORD_FRAC_BITS) - sy;
    len2 = dx * dx + dy * dy;
    dot = px * dx + py * dy;
    crs = py * dx - px * dy;
    m = 0;
    neg = 1'b0;
    case (cfg.shape)
      SHAPE_LINEAR, SHAPE_BILINEAR: begin
        if (len2 != 0) begin
          m = scaled_quotient(magnitude(dot), len2);
          neg = (cfg.shape == SHAPE_LINEAR) && dot < 0;
        end
      end
      SHAPE_RADIAL: begin
        if (len2 != 0) begin
          q = (px * px + py * py) / len2;
          r = (px * px + py * py) % len2;
          root = 0;
          rem = 0;
          // integer digits first, then fraction digits from the remainder
          for (int k = 31; k >= 0; k--) root_digit(root, rem, 2'((q >> (2 * k)) & 3));
          for (int i = 0; i < POS_BITS; i++) begin
            pair = '0;
            for (int j = 0; j < 2; j++) begin
              r = r << 1;
              pair = pair << 1;
              if (r >= len2) begin
                r = r - len2;
                pair[0] = 1'b1;
              end
            end
            root_digit(root, rem, pair);
          end
          m = root;
        end
      end
      SHAPE_SQUARE: begin
        if (len2 != 0) begin
          a = magnitude(crs);
          b = magnitude(dot);
          m = scaled_quotient((a > b) ? a : b, len2);
        end
      end
      SHAPE_CONICAL, SHAPE_CONICAL_SYM: begin
        diff = angle_turns(px, py) - angle_turns(dx, dy);
        if (cfg.shape == SHAPE_CONICAL) m = longint'(diff) >> (32 - POS_BITS);
        else if (diff < HALF_TURN) m = longint'(diff) >> (31 - POS_BITS);
        else m = ((64'd1 << 32) - longint'(diff)) >> (31 - POS_BITS);
      end
      default: m = 0;
    endcase

    fr = m & POS_MAX;
    case (cfg.spread)
      SPREAD_REPEAT: begin
        if (!neg && m != 0) v = fr;
        else v = (fr == 0) ? POS_MAX : POS_ONE - fr;
      end
      SPREAD_MIRROR: begin
        if ((m >> POS_BITS) & 1) v = (POS_ONE - fr > POS_MAX) ? POS_MAX : POS_ONE - fr;
        else v = fr;
      end
      default: begin
        if (neg || m == 0) v = 0;
        else if (m >= POS_ONE) v = POS_MAX;
        else v = m;
      end
    endcase
    if (cfg.reverse) v = POS_MAX - v;
    return v[15:0];
  endfunction

  // Drive the next pending pixel; hold the beat while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_pixel_x <= pending_pixels[0].x;
        in_pixel_y <= pending_pixels[0].y;
        void'(pending_pixels.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at the accepting edge; config is stable while pixels flow.
  always @(posedge clk) begin
    pixel_t pix;
    if (rst_n && in_valid && !in_stall) begin
      pix.x = in_pixel_x;
      pix.y = in_pixel_y;
      expected_positions.push_back(gradient_position(pix));
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        $error("unexpected result beat: position %0d", out_position);
        mismatches++;
      end else begin
        want = expected_positions.pop_front();
        if (out_position !== want) begin
          $error("position mismatch: expected %0d actual %0d", want, out_position);
          mismatches++;
        end
      end
      positions_checked++;
    end
  end

  // Watchdog: count cycles with work outstanding and no beat moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel ||
        positions_checked >= pixels_queued) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_cfg(gradient_cfg_t c);
    write_reg(REG_START_X, 32'(c.start_x));
    write_reg(REG_START_Y, 32'(c.start_y));
    write_reg(REG_END_X, 32'(c.end_x));
    write_reg(REG_END_Y, 32'(c.end_y));
    write_reg(REG_SHAPE, 32'(c.shape));
    write_reg(REG_SPREAD, 32'(c.spread));
    write_reg(REG_REVERSE, 32'(c.reverse));
    cfg = c;
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_t pix;
    pix.x = 16'(x);
    pix.y = 16'(y);
    pending_pixels.push_back(pix);
    pixels_queued++;
  endtask

  // Wait until every queued pixel has come back, then let the pipe settle.
  task automatic drain();
    do @(posedge clk); while (positions_checked < pixels_queued);
    repeat (4) @(posedge clk);
  endtask

  function automatic gradient_cfg_t make_cfg(int sx, int sy, int ex, int ey,
                                             shape_t sh, spread_t sp, bit rev);
    gradient_cfg_t c;
    c.start_x = 20'(sx);
    c.start_y = 20'(sy);
    c.end_x   = 20'(ex);
    c.end_y   = 20'(ey);
    c.shape   = sh;
    c.spread  = sp;
    c.reverse = rev;
    return c;
  endfunction

  function automatic int random_coord20();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 524287 : -524288;
      1: return int'($urandom_range(4095)) - 2048;
      default: return int'($signed(20'($urandom)));
    endcase
  endfunction

  // pixel coordinate near the start point, clipped to 16 bits
  function automatic int near_coord(logic signed [19:0] s, int span);
    int v;
    v = (int'(s) >>> COORD_FRAC_BITS) + int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    gradient_cfg_t c;
    int issued, n, span, sx, sy;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    cfg = make_cfg(0, 0, 0, 0, SHAPE_LINEAR, SPREAD_CLAMP, 1'b0);

    // Directed: linear clamp along x, before, inside and past the vector, extremes.
    load_cfg(make_cfg(0, 0, 160, 0, SHAPE_LINEAR, SPREAD_CLAMP, 1'b0));
    queue_pixel(0, 0); queue_pixel(5, 0); queue_pixel(10, 0); queue_pixel(20, 0);
    queue_pixel(-5, 0); queue_pixel(32767, -32768); queue_pixel(-32768, 32767);
    drain();
    // Bilinear with repeat: zero fraction at the start maps to the maximum.
    load_cfg(make_cfg(0, 0, 160, 0, SHAPE_BILINEAR, SPREAD_REPEAT, 1'b0));
    queue_pixel(-5, 0); queue_pixel(0, 0); queue_pixel(10, 0); queue_pixel(25, 3);
    drain();
    load_cfg(make_cfg(0, 0, 160, 0, SHAPE_RADIAL, SPREAD_MIRROR, 1'b1));
    queue_pixel(15, 0); queue_pixel(7, 7); queue_pixel(-32768, -32768);
    drain();
    // Square with the unused spread code, which behaves as clamp.
    load_cfg(make_cfg(-16, 32, 64, 96, SHAPE_SQUARE, SPREAD_UNUSED3, 1'b0));
    queue_pixel(3, 9); queue_pixel(-8, 2);
    drain();
    // Conical: a pixel on the start point has zero angle; extreme end point.
    load_cfg(make_cfg(160, -320, -524288, 524287, SHAPE_CONICAL, SPREAD_CLAMP, 1'b0));
    queue_pixel(10, -20); queue_pixel(0, 0); queue_pixel(32767, 32767);
    drain();
    load_cfg(make_cfg(160, -320, 524287, -524288, SHAPE_CONICAL_SYM, SPREAD_MIRROR, 1'b1));
    queue_pixel(11, -20); queue_pixel(10, -21);
    drain();
    // Zero-length vector, then the unused shape codes.
    load_cfg(make_cfg(524287, 524287, 524287, 524287, SHAPE_SQUARE, SPREAD_REPEAT, 1'b0));
    queue_pixel(1, 1);
    drain();
    load_cfg(make_cfg(-524288, 0, 160, 16, SHAPE_UNUSED6, SPREAD_CLAMP, 1'b1));
    queue_pixel(4, 4);
    drain();
    load_cfg(make_cfg(0, -524288, 16, 160, SHAPE_UNUSED7, SPREAD_REPEAT, 1'b0));
    queue_pixel(-4, 4);
    drain();

    // Random phases: fresh settings, then a burst of pixels under that setting.
    issued = 0;
    while (issued < RANDOM_PIXELS) begin
      if (issued < RANDOM_PIXELS / 3) begin
        send_idle_pct = 27; recv_idle_pct = 47;
      end else if (issued < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 47; recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      sx = random_coord20();
      sy = random_coord20();
      c = make_cfg(sx, sy, 0, 0, shape_t'($urandom_range(9) < 9 ? $urandom_range(5)
                                                                : $urandom_range(7)),
                   spread_t'($urandom_range(3)), 1'($urandom));
      case ($urandom_range(9))
        0: begin
          c.end_x = c.start_x;
          c.end_y = c.start_y;
        end
        1, 2, 3: begin
          c.end_x = 20'(random_coord20());
          c.end_y = 20'(random_coord20());
        end
        default: begin
          // short vector: positions wrap many times across the pixel spread
          c.end_x = c.start_x + 20'(int'($urandom_range(256)) - 128);
          c.end_y = c.start_y + 20'(int'($urandom_range(256)) - 128);
        end
      endcase
      load_cfg(c);
      span = 4 + int'((magnitude(longint'(c.end_x) - longint'(c.start_x)) +
                       magnitude(longint'(c.end_y) - longint'(c.start_y))) >> 3);
      if (span > 20000) span = 20000;
      n = $urandom_range(20, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) != 0) queue_pixel(near_coord(c.start_x, span),
                                                near_coord(c.start_y, span));
        else queue_pixel(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
      end
      issued += n;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
